// ----- design/ost_pkg.sv -----
package ost_pkg;

  localparam int GRID_SIZE_DEF = 256;
  localparam int TRIG_W = 33;
  localparam int CORDIC_STEPS = 30;

  localparam logic [23:0] STEP_RESET = 24'd6434;
  localparam logic [19:0] G_Q16 = 20'd642908;
  localparam logic [36:0] HALF_PI_Q36 = 37'h1921FB5444;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [TRIG_W-1:0] TRIG_MAX = 33'sd1073741823;

  typedef struct packed {
    logic                     center;
    logic [15:0]              dest;
    logic signed [TRIG_W-1:0] sa;
    logic signed [TRIG_W-1:0] sb;
    logic signed [TRIG_W-1:0] sc;
    logic signed [TRIG_W-1:0] sd;
  } side_t;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input int i);
    logic signed [TRIG_W-1:0] a;
    case (i)
      0: a = 33'sd843314856;
      1: a = 33'sd497837829;
      2: a = 33'sd263043836;
      3: a = 33'sd133525158;
      4: a = 33'sd67021686;
      5: a = 33'sd33543515;
      6: a = 33'sd16775850;
      7: a = 33'sd8388437;
      8: a = 33'sd4194282;
      9: a = 33'sd2097149;
      default: a = 33'sd1 <<< (30 - i);
    endcase
    return a;
  endfunction

endpackage

// ----- design/ost_isqrt.sv -----
module ost_isqrt #(
  parameter int RAD_W = 48,
  parameter int TAG_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     rad,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   root,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W = ROOT_W + 3;

  logic               vld [ROOT_W];
  logic [RAD_W-1:0]   rd  [ROOT_W];
  logic [REM_W-1:0]   rm  [ROOT_W];
  logic [ROOT_W-1:0]  rt  [ROOT_W];
  logic [TAG_W-1:0]   tg  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_digit
    logic              sv;
    logic [RAD_W-1:0]  srd;
    logic [REM_W-1:0]  srm;
    logic [ROOT_W-1:0] srt;
    logic [TAG_W-1:0]  stg;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;

    if (j == 0) begin : g_first
      assign sv = in_valid;
      assign srd = rad;
      assign srm = '0;
      assign srt = '0;
      assign stg = in_tag;
    end else begin : g_next
      assign sv = vld[j-1];
      assign srd = rd[j-1];
      assign srm = rm[j-1];
      assign srt = rt[j-1];
      assign stg = tg[j-1];
    end

    assign cur = {srm[REM_W-3:0], srd[RAD_W-1 -: 2]};
    assign trial = {1'b0, srt, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= sv;
      end
      rd[j] <= srd << 2;
      tg[j] <= stg;
      if (cur >= trial) begin
        rm[j] <= cur - trial;
        rt[j] <= {srt[ROOT_W-2:0], 1'b1};
      end else begin
        rm[j] <= cur;
        rt[j] <= {srt[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root = rt[ROOT_W-1];
  assign out_tag = tg[ROOT_W-1];

endmodule

// ----- design/ost_cordic.sv -----
module ost_cordic #(
  parameter int TAG_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [ost_pkg::TRIG_W-1:0] z_in,
  input  logic [TAG_W-1:0]                  in_tag,
  output logic                              out_valid,
  output logic signed [ost_pkg::TRIG_W-1:0] cos_out,
  output logic signed [ost_pkg::TRIG_W-1:0] sin_out,
  output logic [TAG_W-1:0]                  out_tag
);
  import ost_pkg::*;

  logic                     vld [CORDIC_STEPS];
  logic signed [TRIG_W-1:0] xs  [CORDIC_STEPS];
  logic signed [TRIG_W-1:0] ys  [CORDIC_STEPS];
  logic signed [TRIG_W-1:0] zs  [CORDIC_STEPS];
  logic [TAG_W-1:0]         tg  [CORDIC_STEPS];

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
    localparam logic signed [TRIG_W-1:0] ANG = atan_q30(j);
    logic                     sv;
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] sz;
    logic [TAG_W-1:0]         st;

    if (j == 0) begin : g_first
      assign sv = in_valid;
      assign sx = CORDIC_GAIN;
      assign sy = '0;
      assign sz = z_in;
      assign st = in_tag;
    end else begin : g_next
      assign sv = vld[j-1];
      assign sx = xs[j-1];
      assign sy = ys[j-1];
      assign sz = zs[j-1];
      assign st = tg[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= sv;
      end
      tg[j] <= st;
      if (sz >= 0) begin
        xs[j] <= sx - (sy >>> j);
        ys[j] <= sy + (sx >>> j);
        zs[j] <= sz - ANG;
      end else begin
        xs[j] <= sx + (sy >>> j);
        ys[j] <= sy - (sx >>> j);
        zs[j] <= sz + ANG;
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS-1];
  assign cos_out = xs[CORDIC_STEPS-1];
  assign sin_out = ys[CORDIC_STEPS-1];
  assign out_tag = tg[CORDIC_STEPS-1];

endmodule

// ----- design/ocean_spectrum_time_evolve.sv -----
// Evolves one cell of an ocean wave spectrum per clock. A load transaction (func 0) writes the
// initial amplitude of one grid cell; an evolve transaction (func 1) reads the cell and its
// mirror, computes the dispersion phase from the wavenumber step register and time_q, and
// returns h0*e^(i phase) + conj(h0 mirror)*e^(-i phase) with a half-grid shifted index. busy
// stays low, so a transaction can be issued every cycle. The result of an evolve transaction
// appears on done after it has passed W1 square root digits for |k|, OW square root digits for
// omega, QB phase reduction steps, 30 CORDIC steps and eight further register stages. The
// receiver cannot stall; each result is shown for one cycle only. Loads and cells outside the
// grid give no result. The amplitude store is two-port read, one-port write memory; a cell
// must be loaded before it is evolved.
module ocean_spectrum_time_evolve #(
  parameter int GRID_SIZE = ost_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [7:0]         cell_x,
  input  logic [7:0]         cell_y,
  input  logic signed [31:0] amp_re,
  input  logic signed [31:0] amp_im,
  input  logic [31:0]        time_q,
  input  logic               step_we,
  input  logic [23:0]        step_wdata,
  output logic               done,
  output logic signed [31:0] height_re,
  output logic signed [31:0] height_im,
  output logic [15:0]        dest_index,
  output logic               saturated
);
  import ost_pkg::*;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVOLVE = 1'b1;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam int IW = $clog2(GRID_SIZE);
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW = $clog2(DEPTH);
  localparam int HALF = GRID_SIZE / 2;
  localparam int SW = 2 * IW;
  localparam int R1 = SW + 32;
  localparam int W1 = R1 / 2;
  localparam int KW = W1 + 8;
  localparam int R2 = KW + 28 + (KW % 2);
  localparam int OW = R2 / 2;
  localparam int PW = OW + 32;
  localparam int QB = PW - 36;
  localparam int LAT = W1 + OW + QB + CORDIC_STEPS + 8;

  typedef struct packed {
    side_t       side;
    logic [31:0] tq;
  } itag_t;

  typedef struct packed {
    side_t      side;
    logic [1:0] quad;
  } ctag_t;

  // configuration
  logic [23:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (step_we) begin
      step <= step_wdata;
    end
  end

  assign busy = 1'b0;

  // transaction decode
  logic          in_grid;
  logic          wr_go;
  logic          ev_go;
  logic [AW-1:0] paddr;
  logic [AW-1:0] qaddr;
  logic [IW:0]   mx;
  logic [IW:0]   my;
  logic [IW:0]   xs;
  logic [IW:0]   ys;
  logic [IW:0]   xd;
  logic [IW:0]   yd;
  logic [31:0]   dest_full;
  logic signed [IW+1:0] m;
  logic signed [IW+1:0] n;
  logic signed [2*IW+3:0] mm;
  logic signed [2*IW+3:0] nn;

  assign in_grid = (12'(cell_x) < 12'(GRID_SIZE)) && (12'(cell_y) < 12'(GRID_SIZE));
  assign wr_go = start && !busy && in_grid && (func == FUNC_LOAD);
  assign ev_go = start && !busy && in_grid && (func == FUNC_EVOLVE);

  assign mx = (IW+1)'(GRID_SIZE - 1) - (IW+1)'(cell_x);
  assign my = (IW+1)'(GRID_SIZE - 1) - (IW+1)'(cell_y);
  assign paddr = AW'(cell_y) * AW'(GRID_SIZE) + AW'(cell_x);
  assign qaddr = AW'(my) * AW'(GRID_SIZE) + AW'(mx);

  assign xs = (IW+1)'(cell_x) + (IW+1)'(HALF);
  assign ys = (IW+1)'(cell_y) + (IW+1)'(HALF);
  assign xd = (xs >= (IW+1)'(GRID_SIZE)) ? xs - (IW+1)'(GRID_SIZE) : xs;
  assign yd = (ys >= (IW+1)'(GRID_SIZE)) ? ys - (IW+1)'(GRID_SIZE) : ys;
  assign dest_full = 32'(yd) * 32'(GRID_SIZE) + 32'(xd);

  assign m = $signed((IW+2)'(cell_x)) - $signed((IW+2)'(HALF));
  assign n = $signed((IW+2)'(cell_y)) - $signed((IW+2)'(HALF));
  assign mm = m * m;
  assign nn = n * n;

  // amplitude store
  logic [63:0] mem [DEPTH];
  logic [63:0] rd_p;
  logic [63:0] rd_q;

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[paddr] <= {amp_re, amp_im};
    end
    rd_p <= mem[paddr];
    rd_q <= mem[qaddr];
  end

  // stage 0
  logic          s0_v;
  logic          s0_center;
  logic [15:0]   s0_dest;
  logic [31:0]   s0_tq;
  logic [SW-1:0] s0_ssq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= ev_go;
    end
    s0_center <= (m == '0) && (n == '0);
    s0_dest <= dest_full[15:0];
    s0_tq <= time_q;
    s0_ssq <= SW'(mm + nn);
  end

  // butterfly sums of cell and mirror
  itag_t i1_in;
  logic signed [31:0] re0, im0, re1, im1;

  assign re0 = $signed(rd_p[63:32]);
  assign im0 = $signed(rd_p[31:0]);
  assign re1 = $signed(rd_q[63:32]);
  assign im1 = $signed(rd_q[31:0]);

  always_comb begin
    i1_in.side.center = s0_center;
    i1_in.side.dest = s0_dest;
    i1_in.side.sa = TRIG_W'(re0) + TRIG_W'(re1);
    i1_in.side.sb = TRIG_W'(im0) + TRIG_W'(im1);
    i1_in.side.sc = TRIG_W'(re0) - TRIG_W'(re1);
    i1_in.side.sd = TRIG_W'(im0) - TRIG_W'(im1);
    i1_in.tq = s0_tq;
  end

  // |k| root
  logic          i1_v;
  logic [W1-1:0] i1_root;
  itag_t         i1_tag;

  ost_isqrt #(.RAD_W(R1), .TAG_W($bits(itag_t))) u_isqrt_k (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_v),
    .rad       ({s0_ssq, 32'd0}),
    .in_tag    (i1_in),
    .out_valid (i1_v),
    .root      (i1_root),
    .out_tag   (i1_tag)
  );

  // wavenumber scaling and gravity product
  logic [W1+23:0] kprod;
  logic           k_v;
  logic [KW-1:0]  k;
  itag_t          k_tag;
  logic           g_v;
  logic [36:0]    g_lo;
  logic [KW+2:0]  g_hi;
  itag_t          g_tag;
  logic           r_v;
  logic [R2-1:0]  r_rad;
  itag_t          r_tag;
  logic [KW+19:0] gsum;

  assign kprod = i1_root * step;
  assign gsum = {g_hi, 17'd0} + (KW+20)'(g_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
      g_v <= 1'b0;
      r_v <= 1'b0;
    end else begin
      k_v <= i1_v;
      g_v <= k_v;
      r_v <= g_v;
    end
    k <= kprod[W1+23:16];
    k_tag <= i1_tag;
    g_lo <= k[16:0] * G_Q16;
    g_hi <= k[KW-1:17] * G_Q16;
    g_tag <= k_tag;
    r_rad <= R2'({gsum, 8'd0});
    r_tag <= g_tag;
  end

  // omega root
  logic          i2_v;
  logic [OW-1:0] i2_root;
  itag_t         i2_tag;

  ost_isqrt #(.RAD_W(R2), .TAG_W($bits(itag_t))) u_isqrt_w (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_v),
    .rad       (r_rad),
    .in_tag    (r_tag),
    .out_valid (i2_v),
    .root      (i2_root),
    .out_tag   (i2_tag)
  );

  // phase
  logic [PW-1:0] ph_prod;
  logic          ph_v;
  logic [PW-1:0] ph;
  side_t         ph_side;

  assign ph_prod = i2_root * i2_tag.tq;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_v <= 1'b0;
    end else begin
      ph_v <= i2_v;
    end
    ph <= ph_prod;
    ph_side <= i2_tag.side;
  end

  // phase reduction by pi/2, one quotient bit per stage
  logic          rv   [QB];
  logic [PW-1:0] rrem [QB];
  logic [1:0]    rq   [QB];
  side_t         rsd  [QB];

  for (genvar j = 0; j < QB; j++) begin : g_reduce
    localparam logic [PW-1:0] HK = PW'(HALF_PI_Q36) << (QB - 1 - j);
    logic          sv;
    logic [PW-1:0] srem;
    logic [1:0]    sq;
    side_t         ssd;
    logic          ge;

    if (j == 0) begin : g_first
      assign sv = ph_v;
      assign srem = ph;
      assign sq = '0;
      assign ssd = ph_side;
    end else begin : g_next
      assign sv = rv[j-1];
      assign srem = rrem[j-1];
      assign sq = rq[j-1];
      assign ssd = rsd[j-1];
    end

    assign ge = srem >= HK;

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[j] <= 1'b0;
      end else begin
        rv[j] <= sv;
      end
      rrem[j] <= ge ? srem - HK : srem;
      rq[j] <= {sq[0], ge};
      rsd[j] <= ssd;
    end
  end

  // cordic
  ctag_t                    c_in;
  logic                     c_v;
  logic signed [TRIG_W-1:0] c_x;
  logic signed [TRIG_W-1:0] c_y;
  ctag_t                    c_tag;
  logic signed [TRIG_W-1:0] z0;

  assign z0 = $signed({2'b00, rrem[QB-1][36:6]});
  assign c_in.side = rsd[QB-1];
  assign c_in.quad = rq[QB-1];

  ost_cordic #(.TAG_W($bits(ctag_t))) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rv[QB-1]),
    .z_in      (z0),
    .in_tag    (c_in),
    .out_valid (c_v),
    .cos_out   (c_x),
    .sin_out   (c_y),
    .out_tag   (c_tag)
  );

  // quadrant and clamp
  logic signed [TRIG_W-1:0] qc;
  logic signed [TRIG_W-1:0] qs;
  logic signed [TRIG_W-1:0] cc;
  logic signed [TRIG_W-1:0] cs;
  logic                     t_v;
  logic signed [TRIG_W-1:0] t_c;
  logic signed [TRIG_W-1:0] t_s;
  side_t                    t_side;

  always_comb begin
    case (c_tag.quad)
      QUAD_0: begin
        qc = c_x;
        qs = c_y;
      end
      QUAD_1: begin
        qc = -c_y;
        qs = c_x;
      end
      QUAD_2: begin
        qc = -c_x;
        qs = -c_y;
      end
      default: begin
        qc = c_y;
        qs = -c_x;
      end
    endcase
    cc = (qc > TRIG_MAX) ? TRIG_MAX : ((qc < -TRIG_MAX) ? -TRIG_MAX : qc);
    cs = (qs > TRIG_MAX) ? TRIG_MAX : ((qs < -TRIG_MAX) ? -TRIG_MAX : qs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else begin
      t_v <= c_v;
    end
    t_c <= cc;
    t_s <= cs;
    t_side <= c_tag.side;
  end

  // products
  logic               m_v;
  logic signed [65:0] m_ac;
  logic signed [65:0] m_bs;
  logic signed [65:0] m_cs;
  logic signed [65:0] m_dc;
  side_t              m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else begin
      m_v <= t_v;
    end
    m_ac <= t_side.sa * t_c;
    m_bs <= t_side.sb * t_s;
    m_cs <= t_side.sc * t_s;
    m_dc <= t_side.sd * t_c;
    m_side <= t_side;
  end

  // rounding and saturation
  logic signed [67:0] hr_sum;
  logic signed [67:0] hi_sum;
  logic signed [67:0] hr_sh;
  logic signed [67:0] hi_sh;
  logic               hr_hi, hr_lo, hi_hi, hi_lo;

  assign hr_sum = 68'(m_ac) - 68'(m_bs) + 68'sd536870912;
  assign hi_sum = 68'(m_cs) + 68'(m_dc) + 68'sd536870912;
  assign hr_sh = hr_sum >>> 30;
  assign hi_sh = hi_sum >>> 30;
  assign hr_hi = hr_sh > 68'sd2147483647;
  assign hr_lo = hr_sh < -68'sd2147483648;
  assign hi_hi = hi_sh > 68'sd2147483647;
  assign hi_lo = hi_sh < -68'sd2147483648;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_v;
    end
    dest_index <= m_side.dest;
    if (m_side.center) begin
      height_re <= '0;
      height_im <= '0;
      saturated <= 1'b0;
    end else begin
      height_re <= hr_hi ? 32'sh7fffffff : (hr_lo ? 32'sh80000000 : hr_sh[31:0]);
      height_im <= hi_hi ? 32'sh7fffffff : (hi_lo ? 32'sh80000000 : hi_sh[31:0]);
      saturated <= hr_hi || hr_lo || hi_hi || hi_lo;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ev_go, LAT))
    else $error("result without matching evolve transaction");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (height_re == 32'sh7fffffff || height_re == 32'sh80000000 ||
                           height_im == 32'sh7fffffff || height_im == 32'sh80000000))
    else $error("saturation flag without clipped component");

  a_center: assert property (@(posedge clk) disable iff (rst)
    m_v && m_side.center |=> done && height_re == '0 && height_im == '0 && !saturated)
    else $error("centre cell result not zero");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import ost_pkg::*;

  localparam int HALF = 128;
  localparam int LIMIT = 1000000;
  localparam int DRAIN = 300;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [15:0]        idx;
    logic               sat;
  } height_t;

  class spectrum_sb;
    bit [63:0] amp_store [65536];
    bit [23:0] step;
    height_t   heights_q [$];
    int        errors;
    longint    atan_tab [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                                 33543515, 16775850, 8388437, 4194282, 2097149};

    function new();
      step = STEP_RESET;
      errors = 0;
    endfunction

    function void set_step(bit [23:0] v);
      step = v;
    endfunction

    function int pending();
      return heights_q.size();
    endfunction

    function bit [63:0] isqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void sincos(bit [63:0] phase, output longint c, output longint s);
      bit [63:0] h, r, q;
      longint xx, yy, z, ang, dx, dy;
      h = 64'(HALF_PI_Q36);
      r = phase % (4 * h);
      q = r / h;
      z = longint'((r - q * h) >> 6);
      xx = longint'(CORDIC_GAIN);
      yy = 0;
      for (int i = 0; i < 30; i++) begin
        ang = (i < 10) ? atan_tab[i] : (longint'(1) <<< (30 - i));
        dx = yy >>> i;
        dy = xx >>> i;
        if (z >= 0) begin
          xx -= dx; yy += dy; z -= ang;
        end else begin
          xx += dx; yy -= dy; z += ang;
        end
      end
      case (q[1:0])
        2'd0: begin c = xx;  s = yy;  end
        2'd1: begin c = -yy; s = xx;  end
        2'd2: begin c = -xx; s = -yy; end
        default: begin c = yy; s = -xx; end
      endcase
      if (c > longint'(TRIG_MAX)) c = longint'(TRIG_MAX);
      if (c < -longint'(TRIG_MAX)) c = -longint'(TRIG_MAX);
      if (s > longint'(TRIG_MAX)) s = longint'(TRIG_MAX);
      if (s < -longint'(TRIG_MAX)) s = -longint'(TRIG_MAX);
    endfunction

    function logic signed [31:0] clip(longint v, inout logic flag);
      if (v > 64'sd2147483647) begin flag = 1; return 32'sh7fffffff; end
      if (v < -64'sd2147483648) begin flag = 1; return 32'sh80000000; end
      return v[31:0];
    endfunction

    function void note(bit f, bit [7:0] x, bit [7:0] y, bit [31:0] are, bit [31:0] aim,
                       bit [31:0] t);
      height_t e;
      longint m, n, re0, im0, re1, im1, c, s, hre, him;
      bit [63:0] rr, kmag, omega, phase, p, q;
      bit [7:0] dx, dy;
      if (!f) begin
        amp_store[{y, x}] = {are, aim};
        return;
      end
      hre = 0;
      him = 0;
      e.sat = 0;
      if (!(x == HALF && y == HALF)) begin
        m = longint'(x) - HALF;
        n = longint'(y) - HALF;
        rr = isqrt(64'(m * m + n * n) << 32);
        kmag = (rr * 64'(step)) >> 16;
        omega = isqrt((kmag * 64'(G_Q16)) << 8);
        phase = omega * 64'(t);
        p = amp_store[{y, x}];
        q = amp_store[{8'd255 - y, 8'd255 - x}];
        re0 = longint'(signed'(p[63:32]));
        im0 = longint'(signed'(p[31:0]));
        re1 = longint'(signed'(q[63:32]));
        im1 = longint'(signed'(q[31:0]));
        sincos(phase, c, s);
        hre = ((re0 + re1) * c - (im0 + im1) * s + (longint'(1) <<< 29)) >>> 30;
        him = ((re0 - re1) * s + (im0 - im1) * c + (longint'(1) <<< 29)) >>> 30;
      end
      e.re = clip(hre, e.sat);
      e.im = clip(him, e.sat);
      dx = x + 8'd128;
      dy = y + 8'd128;
      e.idx = {dy, dx};
      heights_q.push_back(e);
    endfunction

    function void check(logic signed [31:0] re, logic signed [31:0] im, logic [15:0] idx,
                        logic sat);
      height_t e;
      if (heights_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result re=%0d im=%0d idx=%0d", re, im, idx);
        return;
      end
      e = heights_q.pop_front();
      if (re !== e.re || im !== e.im || idx !== e.idx || sat !== e.sat) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp re=%0d im=%0d idx=%0d sat=%0d got re=%0d im=%0d idx=%0d sat=%0d",
                   e.re, e.im, e.idx, e.sat, re, im, idx, sat);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic               func = 0;
  logic [7:0]         cell_x = 0;
  logic [7:0]         cell_y = 0;
  logic signed [31:0] amp_re = 0;
  logic signed [31:0] amp_im = 0;
  logic [31:0]        time_q = 0;
  logic               step_we = 0;
  logic [23:0]        step_wdata = 0;
  logic               done;
  logic signed [31:0] height_re;
  logic signed [31:0] height_im;
  logic [15:0]        dest_index;
  logic               saturated;

  spectrum_sb sb = new();
  bit   loaded [65536];
  int   burst_left = 0;
  bit   steady = 0;
  int   cycles = 0;

  ocean_spectrum_time_evolve i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .cell_x(cell_x), .cell_y(cell_y), .amp_re(amp_re), .amp_im(amp_im), .time_q(time_q),
    .step_we(step_we), .step_wdata(step_wdata), .done(done), .height_re(height_re),
    .height_im(height_im), .dest_index(dest_index), .saturated(saturated)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (step_we) sb.set_step(step_wdata);
      if (start && !busy) sb.note(func, cell_x, cell_y, amp_re, amp_im, time_q);
      if (done) sb.check(height_re, height_im, dest_index, saturated);
    end
  end

  function automatic bit [31:0] rnd32();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic bit [31:0] rnd_time();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004ffff);
      default: return $urandom_range(0, 32'h00ffffff);
    endcase
  endfunction

  task automatic pace();
    int n;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      n = $urandom_range(1, 8);
      @(negedge clk) start = 0;
      repeat (n - 1) @(negedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic send(bit f, bit [7:0] x, bit [7:0] y, bit [31:0] re, bit [31:0] im,
                      bit [31:0] t);
    @(negedge clk);
    start = 1;
    func = f;
    cell_x = x;
    cell_y = y;
    amp_re = re;
    amp_im = im;
    time_q = t;
    if (!f) loaded[{y, x}] = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pace();
  endtask

  // make sure a cell and its mirror hold data before the evolve transaction
  task automatic evolve(bit [7:0] x, bit [7:0] y, bit [31:0] t);
    if (!loaded[{y, x}]) send(0, x, y, rnd32(), rnd32(), $urandom());
    if (!loaded[{8'd255 - y, 8'd255 - x}])
      send(0, 8'd255 - x, 8'd255 - y, rnd32(), rnd32(), $urandom());
    send(1, x, y, rnd32(), rnd32(), t);
  endtask

  task automatic drain();
    @(negedge clk) start = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_step(bit [23:0] v);
    drain();
    @(negedge clk);
    step_we = 1;
    step_wdata = v;
    @(negedge clk);
    step_we = 0;
    step_wdata = 24'($urandom());
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 3)
        send(0, 8'($urandom()), 8'($urandom()), rnd32(), rnd32(), $urandom());
      else if ($urandom_range(0, 39) == 0)
        evolve(8'd128, 8'd128, rnd_time());
      else
        evolve(8'($urandom()), 8'($urandom()), rnd_time());
    end
    steady = 0;
  endtask

  initial begin
    bit [23:0] steps [6];
    steps = '{24'd1, 24'hffffff, 24'd0, 24'd0, 24'd6434, 24'd0};
    steps[2] = 24'($urandom_range(1, 24'hffffff));
    steps[3] = 24'($urandom_range(1, 20000));
    steps[5] = 24'($urandom_range(1, 24'hffffff));
    step_wdata = 24'($urandom());
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: extremes, centre, saturation
    send(0, 8'd10, 8'd20, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
    send(0, 8'd245, 8'd235, 32'h7fffffff, 32'h80000000, 32'h0);
    send(1, 8'd10, 8'd20, 32'h0, 32'h0, 32'h0);
    send(1, 8'd245, 8'd235, 32'h0, 32'h0, 32'hffffffff);
    send(0, 8'd0, 8'd0, 32'h80000000, 32'h80000000, 32'h0);
    send(0, 8'd255, 8'd255, 32'h80000000, 32'h7fffffff, 32'h0);
    send(1, 8'd0, 8'd0, 32'hffffffff, 32'hffffffff, 32'h0);
    send(1, 8'd255, 8'd255, 32'h0, 32'h0, 32'h00010000);
    send(0, 8'd128, 8'd128, 32'h12345678, 32'h9abcdef0, 32'h0);
    send(0, 8'd127, 8'd127, 32'h00100000, 32'hfff00000, 32'h0);
    send(1, 8'd128, 8'd128, 32'h0, 32'h0, 32'hffffffff);
    send(1, 8'd127, 8'd127, 32'h0, 32'h0, 32'h00008000);
    evolve(8'd0, 8'd255, 32'hffffffff);
    evolve(8'd255, 8'd0, 32'h80000000);
    evolve(8'd128, 8'd0, 32'h00000001);
    evolve(8'd0, 8'd128, 32'h7fffffff);
    random_phase(80);

    foreach (steps[j]) begin
      write_step(steps[j]);
      evolve(8'd0, 8'd0, 32'hffffffff);
      evolve(8'd128, 8'd128, 32'h0);
      random_phase(80);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
